// File: src/blf_pkg.sv
`default_nettype none
package blf_pkg;

  // Operation codes of an input request
  localparam logic OP_LAUNCH = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_SCALE = 2'd1;

  localparam logic [23:0] SPEED_RST  = 24'd256000;
  localparam logic [15:0] GSCALE_RST = 16'd4096;
  localparam logic [9:0]  GRAV_CMS2  = 10'd980;

  // Shared unit step counts: quotient numerators stay below 2^84
  localparam int unsigned DIV_BITS = 84;
  localparam logic [6:0]  DIV_CNT  = 7'(DIV_BITS);
  localparam logic [6:0]  SQRT_CNT = 7'd64;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GX,
    S_GY,
    S_GD2X,
    S_GD2Y,
    S_V2,
    S_P,
    S_GZ,
    S_T,
    S_CMP,
    S_SD,
    S_BM,
    S_BM2,
    S_H,
    S_HCHK,
    S_VG,
    S_L2,
    S_LEN,
    S_LCHK,
    S_NUM,
    S_DIV,
    S_TG,
    S_TV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [15:0]        delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic signed [31:0] location_x;
    logic signed [31:0] location_y;
    logic signed [31:0] location_z;
    logic               reachable;
  } out_item_t;

  typedef struct packed {
    logic         start;
    alu_op_e      op;
    logic [127:0] a;
    logic [63:0]  b;
    logic [127:0] c;
  } alu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } alu_rsp_t;

endpackage
`default_nettype wire

// File: src/blf_alu.sv
`default_nettype none
// Shared shift-add multiplier, restoring divider and digit square root.
// MUL: res = c + a*b, one multiplier bit a cycle, ends when b runs out.
// DIV: res[31:0] = low quotient bits of a/b. SQRT: res = floor(sqrt(a)).
module blf_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blf_pkg::alu_req_t  req_i,
  output blf_pkg::alu_rsp_t  rsp_o
);

  logic             run_q;
  blf_pkg::alu_op_e op_q;
  logic [127:0]     acc_q;
  logic [127:0]     mc_q;
  logic [63:0]      mp_q;
  logic [63:0]      dv_q;
  logic [6:0]       cnt_q;

  logic             sub;
  logic [127:0]     x;
  logic [127:0]     y;
  logic [127:0]     sum;
  logic             carry;
  logic             last;

  always_comb begin
    case (op_q)
      blf_pkg::ALU_DIV: begin
        x = {acc_q[126:0], mc_q[blf_pkg::DIV_BITS-1]};
        y = {64'b0, dv_q};
      end
      blf_pkg::ALU_SQRT: begin
        x = {acc_q[125:0], mc_q[127:126]};
        y = {62'b0, mp_q, 2'b01};
      end
      default: begin
        x = acc_q;
        y = mc_q;
      end
    endcase
    sub = (op_q != blf_pkg::ALU_MUL);
    {carry, sum} = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {128'b0, sub};
    last = (op_q == blf_pkg::ALU_MUL) ? (mp_q == '0) : (cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (req_i.start) begin
      run_q <= 1'b1;
    end else if (run_q && last) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      mc_q  <= req_i.a;
      dv_q  <= req_i.b;
      mp_q  <= (req_i.op == blf_pkg::ALU_MUL) ? req_i.b : '0;
      acc_q <= (req_i.op == blf_pkg::ALU_MUL) ? req_i.c : '0;
      cnt_q <= (req_i.op == blf_pkg::ALU_DIV) ? blf_pkg::DIV_CNT : blf_pkg::SQRT_CNT;
    end else if (run_q && !last) begin
      case (op_q)
        blf_pkg::ALU_DIV, blf_pkg::ALU_SQRT: begin
          acc_q <= carry ? sum : x;
          mp_q  <= {mp_q[62:0], carry};
          mc_q  <= (op_q == blf_pkg::ALU_SQRT) ? (mc_q << 2) : (mc_q << 1);
          cnt_q <= cnt_q - 1'b1;
        end
        default: begin
          if (mp_q[0]) begin
            acc_q <= sum;
          end
          mc_q <= mc_q << 1;
          mp_q <= mp_q >> 1;
        end
      endcase
    end
  end

  assign rsp_o.done = run_q && last;
  assign rsp_o.res  = (op_q == blf_pkg::ALU_MUL) ? acc_q : {64'b0, mp_q};

endmodule
`default_nettype wire

// File: src/ballistic_launch_and_flight.sv
`default_nettype none
// Channel   Direction  Signals                                   Moves
// in        sink       in_valid_i / in_ready_o / in_data_i       launch or tick request
// out       source     out_valid_o / out_ready_i / out_data_o    velocity, location, reachable
// cfg       sink       cfg_valid_i / cfg_ready_o / cfg_index_i   register write request
//                      cfg_data_i
//
// One request is worked at a time through the shared multiply/divide/sqrt unit.
// Tick: four multiplier passes over the 16-bit tick length. Launch: its run time is
// set by the wide multiplies, the 64-step square roots and the 84-step divides of
// the arc solve.
// Reset clears velocity, location, reachable and restores the config registers.
// A finished result waits in the output register; the next request is taken
// meanwhile, and a new result holds in the final state until that register frees.
module ballistic_launch_and_flight (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  blf_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output blf_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [blf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [blf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  blf_pkg::state_e    state_q, state_d;
  blf_pkg::alu_req_t  alu_req;
  blf_pkg::alu_rsp_t  alu_rsp;
  blf_pkg::out_item_t out_q;
  logic               out_valid_q;

  logic [23:0]  speed_q;
  logic [15:0]  gscale_q;
  logic [31:0]  vel_q [3];
  logic [31:0]  pos_q [3];
  logic         reach_q;

  // Per-request working registers
  logic [31:0]  mag_q [3];
  logic         neg_q [3];
  logic [15:0]  dt_q;
  logic [63:0]  gx_q;
  logic [63:0]  gy_q;
  logic [63:0]  v2_q;
  logic [63:0]  w_q;
  logic [63:0]  h_q;
  logic [127:0] gd2_q;
  logic [127:0] p_q;
  logic [127:0] n_q;
  logic [127:0] tmp_q;
  logic         bneg_q;
  logic         aim_q;
  logic [1:0]   lane_q;
  logic         pend_q;

  logic         in_acc;
  logic         alu_state;
  logic         done;
  logic         finish;
  logic [25:0]  grav_w;
  logic [31:0]  st_w [3];
  logic [31:0]  tg_w [3];
  logic [32:0]  dl_w [3];
  logic [32:0]  dln_w [3];
  logic [31:0]  mag_w [3];
  logic [31:0]  vabs;
  logic [63:0]  v2s;
  logic         bneg_w;
  logic [31:0]  quo;
  logic         qneg;
  logic [33:0]  vz_new;
  logic [31:0]  step_m;
  logic [32:0]  step_d;
  logic [33:0]  pos_new;

  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32] || v[31])) begin
      r = 32'h7fff_ffff;
    end else if (v[33] && !(v[32] && v[31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign in_ready_o  = (state_q == blf_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign done        = alu_rsp.done;
  assign finish      = (state_q == blf_pkg::S_OUT) && (!out_valid_q || out_ready_i);

  assign grav_w = {10'b0, gscale_q} * {16'b0, blf_pkg::GRAV_CMS2};

  assign st_w[0] = in_data_i.start_x;
  assign st_w[1] = in_data_i.start_y;
  assign st_w[2] = in_data_i.start_z;
  assign tg_w[0] = in_data_i.target_x;
  assign tg_w[1] = in_data_i.target_y;
  assign tg_w[2] = in_data_i.target_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dl_w[i]  = {tg_w[i][31], tg_w[i]} - {st_w[i][31], st_w[i]};
      dln_w[i] = ~dl_w[i] + 33'd1;
      mag_w[i] = dl_w[i][32] ? dln_w[i][31:0] : dl_w[i][31:0];
    end
  end

  // Working values read around the shared unit
  always_comb begin
    vabs   = vel_q[lane_q][31] ? (~vel_q[lane_q] + 32'd1) : vel_q[lane_q];
    v2s    = v2_q << 4;
    bneg_w = w_q > v2s;
    quo    = alu_rsp.res[31:0];
    qneg   = (aim_q || lane_q != 2'd2) ? neg_q[lane_q] : bneg_q;
    vz_new = {{2{vel_q[2][31]}}, vel_q[2]} - {12'b0, alu_rsp.res[41:20]};
    step_m = alu_rsp.res[47:16];
    step_d = vel_q[lane_q][31] ? (~{1'b0, step_m} + 33'd1) : {1'b0, step_m};
    pos_new = {{2{pos_q[lane_q][31]}}, pos_q[lane_q]} + {step_d[32], step_d};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      blf_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.operation == blf_pkg::OP_TICK) ? blf_pkg::S_TG
                                                               : blf_pkg::S_GX;
        end
      end
      blf_pkg::S_GX:   if (done) state_d = blf_pkg::S_GY;
      blf_pkg::S_GY:   if (done) state_d = blf_pkg::S_GD2X;
      blf_pkg::S_GD2X: if (done) state_d = blf_pkg::S_GD2Y;
      blf_pkg::S_GD2Y: if (done) state_d = blf_pkg::S_V2;
      blf_pkg::S_V2:   if (done) state_d = blf_pkg::S_P;
      blf_pkg::S_P:    if (done) state_d = blf_pkg::S_GZ;
      blf_pkg::S_GZ:   if (done) state_d = blf_pkg::S_T;
      blf_pkg::S_T:    if (done) state_d = blf_pkg::S_CMP;
      blf_pkg::S_CMP: begin
        if (mag_q[0] == '0 && mag_q[1] == '0) begin
          state_d = blf_pkg::S_OUT;
        end else if (p_q < n_q) begin
          state_d = blf_pkg::S_L2;
        end else begin
          state_d = blf_pkg::S_SD;
        end
      end
      blf_pkg::S_SD:   if (done) state_d = blf_pkg::S_BM;
      blf_pkg::S_BM:   state_d = blf_pkg::S_BM2;
      blf_pkg::S_BM2:  if (done) state_d = blf_pkg::S_H;
      blf_pkg::S_H:    if (done) state_d = blf_pkg::S_HCHK;
      blf_pkg::S_HCHK: state_d = (h_q == '0) ? blf_pkg::S_L2 : blf_pkg::S_VG;
      blf_pkg::S_VG:   if (done) state_d = blf_pkg::S_NUM;
      blf_pkg::S_L2:   if (done && lane_q == 2'd2) state_d = blf_pkg::S_LEN;
      blf_pkg::S_LEN:  if (done) state_d = blf_pkg::S_LCHK;
      blf_pkg::S_LCHK: state_d = (h_q == '0) ? blf_pkg::S_OUT : blf_pkg::S_NUM;
      blf_pkg::S_NUM:  if (done) state_d = blf_pkg::S_DIV;
      blf_pkg::S_DIV: begin
        if (done) state_d = (lane_q == 2'd2) ? blf_pkg::S_OUT : blf_pkg::S_NUM;
      end
      blf_pkg::S_TG:   if (done) state_d = blf_pkg::S_TV;
      blf_pkg::S_TV:   if (done && lane_q == 2'd2) state_d = blf_pkg::S_OUT;
      blf_pkg::S_OUT:  if (finish) state_d = blf_pkg::S_IDLE;
      default:         state_d = blf_pkg::S_IDLE;
    endcase
  end

  // Shared unit request for each step
  always_comb begin
    alu_state = state_q inside {blf_pkg::S_GX, blf_pkg::S_GY, blf_pkg::S_GD2X,
                                blf_pkg::S_GD2Y, blf_pkg::S_V2, blf_pkg::S_P,
                                blf_pkg::S_GZ, blf_pkg::S_T, blf_pkg::S_SD,
                                blf_pkg::S_BM2, blf_pkg::S_H, blf_pkg::S_VG,
                                blf_pkg::S_L2, blf_pkg::S_LEN, blf_pkg::S_NUM,
                                blf_pkg::S_DIV, blf_pkg::S_TG, blf_pkg::S_TV};
    alu_req       = '0;
    alu_req.op    = blf_pkg::ALU_MUL;
    alu_req.start = alu_state && !pend_q;
    case (state_q)
      blf_pkg::S_GX: begin
        alu_req.a = 128'(mag_q[0]);
        alu_req.b = 64'(grav_w);
      end
      blf_pkg::S_GY: begin
        alu_req.a = 128'(mag_q[1]);
        alu_req.b = 64'(grav_w);
      end
      blf_pkg::S_GD2X: begin
        alu_req.a = 128'(gx_q);
        alu_req.b = gx_q;
      end
      blf_pkg::S_GD2Y: begin
        alu_req.a = 128'(gy_q);
        alu_req.b = gy_q;
        alu_req.c = gd2_q;
      end
      blf_pkg::S_V2: begin
        alu_req.a = 128'(speed_q);
        alu_req.b = 64'(speed_q);
      end
      blf_pkg::S_P: begin
        alu_req.a = 128'(v2_q) << 8;
        alu_req.b = v2_q;
      end
      blf_pkg::S_GZ: begin
        alu_req.a = 128'(mag_q[2]);
        alu_req.b = 64'(grav_w);
      end
      blf_pkg::S_T: begin
        alu_req.a = 128'(w_q) << 5;
        alu_req.b = v2_q;
        alu_req.c = neg_q[2] ? p_q : gd2_q;
      end
      blf_pkg::S_SD: begin
        alu_req.op = blf_pkg::ALU_SQRT;
        alu_req.a  = p_q - n_q;
      end
      blf_pkg::S_BM2: begin
        alu_req.a = 128'(w_q);
        alu_req.b = w_q;
        alu_req.c = gd2_q;
      end
      blf_pkg::S_H, blf_pkg::S_LEN: begin
        alu_req.op = blf_pkg::ALU_SQRT;
        alu_req.a  = tmp_q;
      end
      blf_pkg::S_VG: begin
        alu_req.a = 128'(grav_w);
        alu_req.b = 64'(speed_q);
      end
      blf_pkg::S_L2: begin
        alu_req.a = 128'(mag_q[lane_q]);
        alu_req.b = 64'(mag_q[lane_q]);
        alu_req.c = (lane_q == 2'd0) ? '0 : tmp_q;
      end
      blf_pkg::S_NUM: begin
        if (aim_q) begin
          alu_req.a = 128'(mag_q[lane_q]);
          alu_req.b = 64'(speed_q);
        end else if (lane_q != 2'd2) begin
          alu_req.a = 128'(gx_q);
          alu_req.b = 64'(mag_q[lane_q]);
        end else begin
          alu_req.a = 128'(w_q);
          alu_req.b = 64'(speed_q);
        end
      end
      blf_pkg::S_DIV: begin
        alu_req.op = blf_pkg::ALU_DIV;
        alu_req.a  = tmp_q;
        alu_req.b  = h_q;
      end
      blf_pkg::S_TG: begin
        alu_req.a = 128'(grav_w);
        alu_req.b = 64'(dt_q);
      end
      blf_pkg::S_TV: begin
        alu_req.a = 128'(vabs);
        alu_req.b = 64'(dt_q);
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  blf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blf_pkg::S_IDLE;
      pend_q      <= 1'b0;
      lane_q      <= 2'd0;
      out_valid_q <= 1'b0;
      speed_q     <= blf_pkg::SPEED_RST;
      gscale_q    <= blf_pkg::GSCALE_RST;
      reach_q     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (alu_req.start) begin
        pend_q <= 1'b1;
      end else if (done) begin
        pend_q <= 1'b0;
      end

      if (done && (state_q == blf_pkg::S_L2 || state_q == blf_pkg::S_DIV ||
                   state_q == blf_pkg::S_TV)) begin
        lane_q <= (lane_q == 2'd2) ? 2'd0 : lane_q + 2'd1;
      end

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          blf_pkg::CFG_LAUNCH_SPEED:  speed_q  <= cfg_data_i[23:0];
          blf_pkg::CFG_GRAVITY_SCALE: gscale_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // Launch places the projectile at the start position
      if (in_acc && in_data_i.operation == blf_pkg::OP_LAUNCH) begin
        for (int i = 0; i < 3; i++) begin
          pos_q[i] <= st_w[i];
        end
      end

      case (state_q)
        blf_pkg::S_CMP: begin
          reach_q <= (p_q >= n_q);
          if (mag_q[0] == '0 && mag_q[1] == '0) begin
            vel_q[0] <= '0;
            vel_q[1] <= '0;
            vel_q[2] <= neg_q[2] ? (~{8'b0, speed_q} + 32'd1) : {8'b0, speed_q};
          end
        end
        blf_pkg::S_LCHK: begin
          if (h_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              vel_q[i] <= '0;
            end
          end
        end
        blf_pkg::S_DIV: begin
          if (done) vel_q[lane_q] <= qneg ? (~quo + 32'd1) : quo;
        end
        blf_pkg::S_TG: begin
          if (done) vel_q[2] <= sat32(vz_new);
        end
        blf_pkg::S_TV: begin
          if (done) pos_q[lane_q] <= sat32(pos_new);
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q <= in_data_i.delta_time;
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= mag_w[i];
        neg_q[i] <= dl_w[i][32];
      end
    end
    if (finish) begin
      out_q.velocity_x <= vel_q[0];
      out_q.velocity_y <= vel_q[1];
      out_q.velocity_z <= vel_q[2];
      out_q.location_x <= pos_q[0];
      out_q.location_y <= pos_q[1];
      out_q.location_z <= pos_q[2];
      out_q.reachable  <= reach_q;
    end
    case (state_q)
      blf_pkg::S_GX:   if (done) gx_q  <= alu_rsp.res[63:0];
      blf_pkg::S_GY:   if (done) gy_q  <= alu_rsp.res[63:0];
      blf_pkg::S_GD2X, blf_pkg::S_GD2Y: begin
        if (done) gd2_q <= alu_rsp.res;
      end
      blf_pkg::S_V2:   if (done) v2_q  <= alu_rsp.res[63:0];
      blf_pkg::S_P:    if (done) p_q   <= alu_rsp.res;
      blf_pkg::S_GZ:   if (done) w_q   <= alu_rsp.res[63:0];
      blf_pkg::S_T: begin
        if (done) begin
          if (neg_q[2]) begin
            p_q <= alu_rsp.res;
            n_q <= gd2_q;
          end else begin
            n_q <= alu_rsp.res;
          end
        end
      end
      blf_pkg::S_CMP:  aim_q <= 1'b1;
      blf_pkg::S_SD:   if (done) w_q <= alu_rsp.res[63:0];
      blf_pkg::S_BM: begin
        bneg_q <= bneg_w;
        w_q    <= bneg_w ? (w_q - v2s) : (v2s - w_q);
      end
      blf_pkg::S_BM2, blf_pkg::S_L2, blf_pkg::S_NUM: begin
        if (done) tmp_q <= alu_rsp.res;
      end
      blf_pkg::S_H, blf_pkg::S_LEN: begin
        if (done) h_q <= alu_rsp.res[63:0];
      end
      blf_pkg::S_HCHK: aim_q <= (h_q == '0);
      // Reuse gx for v*g once the squares are formed
      blf_pkg::S_VG:   if (done) gx_q <= alu_rsp.res[63:0];
      default: ;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != blf_pkg::S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_done_when_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> pend_q)
    else $error("shared unit finished without an issued step");

  a_idle_nothing_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == blf_pkg::S_IDLE |-> !pend_q)
    else $error("idle with a shared unit step still running");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == blf_pkg::S_OUT)
    else $error("result raised outside the final state");

endmodule
`default_nettype wire
